FILE: rtl/core/bwc_pkg.sv
// Shared widths, constants and the blob record type of the weighted centroid block.
package bwc_pkg;

   localparam int COORD_WIDTH   = 12;
   localparam int COUNT_WIDTH   = 24;
   localparam int WEIGHT_WIDTH  = 8;
   localparam int WSUM_WIDTH    = 32;
   localparam int SUM_WIDTH     = 44;
   localparam int MINPIX_WIDTH  = 16;
   localparam int MINPIX_RESET  = 30;
   localparam int PROD_WIDTH    = COORD_WIDTH + WEIGHT_WIDTH;
   localparam int DIV_WIDTH     = (WSUM_WIDTH + COORD_WIDTH > SUM_WIDTH) ?
                                  (WSUM_WIDTH + COORD_WIDTH) : SUM_WIDTH;
   localparam int STEP_WIDTH    = $clog2(COORD_WIDTH);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_WIDTH    = 1;
   localparam int QCNT_WIDTH    = 2;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] count;
      logic [WSUM_WIDTH-1:0]  wsum;
      logic [SUM_WIDTH-1:0]   xsum;
      logic [SUM_WIDTH-1:0]   ysum;
   } bwc_blob_type;

endpackage

FILE: rtl/core/bwc_front.sv
// Pixel front end: weighted products and saturating blob accumulators.
module bwc_front import bwc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [MINPIX_WIDTH-1:0] min_pixels,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [COORD_WIDTH-1:0]  pixel_x,
   input  logic [COORD_WIDTH-1:0]  pixel_y,
   input  logic [WEIGHT_WIDTH-1:0] pixel_weight,
   input  logic                    last_pixel,
   output logic                    push_valid,
   input  logic                    push_ready,
   output bwc_blob_type            push_blob
);

   logic                    a_valid_ff, a_valid_in;
   logic [PROD_WIDTH-1:0]   a_xw_ff;
   logic [PROD_WIDTH-1:0]   a_yw_ff;
   logic [WEIGHT_WIDTH-1:0] a_w_ff;
   logic                    a_last_ff;
   logic                    a_advance;
   logic                    req_fire;
   logic                    keep;

   logic [COUNT_WIDTH-1:0]  count_ff, count_in, count_nx;
   logic [WSUM_WIDTH-1:0]   wsum_ff, wsum_in, wsum_nx;
   logic [SUM_WIDTH-1:0]    xsum_ff, xsum_in, xsum_nx;
   logic [SUM_WIDTH-1:0]    ysum_ff, ysum_in, ysum_nx;

   logic [COUNT_WIDTH:0]    count_add;
   logic [WSUM_WIDTH:0]     wsum_add;
   logic [SUM_WIDTH:0]      xsum_add;
   logic [SUM_WIDTH:0]      ysum_add;

   assign req_fire  = req_valid && req_ready;
   assign count_add = {1'b0, count_ff} + (COUNT_WIDTH+1)'(1);
   assign wsum_add  = {1'b0, wsum_ff} + (WSUM_WIDTH+1)'(a_w_ff);
   assign xsum_add  = {1'b0, xsum_ff} + (SUM_WIDTH+1)'(a_xw_ff);
   assign ysum_add  = {1'b0, ysum_ff} + (SUM_WIDTH+1)'(a_yw_ff);

   assign count_nx = count_add[COUNT_WIDTH] ? '1 : count_add[COUNT_WIDTH-1:0];
   assign wsum_nx  = wsum_add[WSUM_WIDTH]   ? '1 : wsum_add[WSUM_WIDTH-1:0];
   assign xsum_nx  = xsum_add[SUM_WIDTH]    ? '1 : xsum_add[SUM_WIDTH-1:0];
   assign ysum_nx  = ysum_add[SUM_WIDTH]    ? '1 : ysum_add[SUM_WIDTH-1:0];

   assign keep       = 32'(count_nx) > 32'(min_pixels);
   assign push_valid = a_valid_ff && a_last_ff && keep;
   assign a_advance  = a_valid_ff && (!(a_last_ff && keep) || push_ready);
   assign req_ready  = !a_valid_ff || a_advance;
   assign a_valid_in = req_fire || (a_valid_ff && !a_advance);

   assign push_blob.count = count_nx;
   assign push_blob.wsum  = wsum_nx;
   assign push_blob.xsum  = xsum_nx;
   assign push_blob.ysum  = ysum_nx;

   always_comb begin
      count_in = count_ff;
      wsum_in  = wsum_ff;
      xsum_in  = xsum_ff;
      ysum_in  = ysum_ff;
      if (a_advance) begin
         if (a_last_ff) begin
            count_in = '0;
            wsum_in  = '0;
            xsum_in  = '0;
            ysum_in  = '0;
         end else begin
            count_in = count_nx;
            wsum_in  = wsum_nx;
            xsum_in  = xsum_nx;
            ysum_in  = ysum_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         count_ff   <= '0;
         wsum_ff    <= '0;
         xsum_ff    <= '0;
         ysum_ff    <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         count_ff   <= count_in;
         wsum_ff    <= wsum_in;
         xsum_ff    <= xsum_in;
         ysum_ff    <= ysum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_xw_ff   <= PROD_WIDTH'(pixel_x) * PROD_WIDTH'(pixel_weight);
         a_yw_ff   <= PROD_WIDTH'(pixel_y) * PROD_WIDTH'(pixel_weight);
         a_w_ff    <= pixel_weight;
         a_last_ff <= last_pixel;
      end
   end

`ifndef NO_ASSERTIONS
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (a_advance && a_last_ff) |=> (count_ff == '0 && wsum_ff == '0))
      else $error("Accumulators did not clear after the last pixel of a blob.");

   a_push_above_min: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (32'(push_blob.count) > 32'(min_pixels)))
      else $error("A blob at or below the minimum size was forwarded.");
`endif

endmodule

FILE: rtl/core/bwc_queue.sv
// Two-entry queue of finished blob sums between the front end and the divider.
module bwc_queue import bwc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  bwc_blob_type push_blob,
   output logic         pop_valid,
   input  logic         pop_ready,
   output bwc_blob_type pop_blob
);

   bwc_blob_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]  count_ff, count_in;
   logic                   push_fire;
   logic                   pop_fire;

   assign push_ready = count_ff != QCNT_WIDTH'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_blob   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + QPTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = pop_fire  ? rd_ptr_ff + QPTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + QCNT_WIDTH'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - QCNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_blob;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_tracks_push: assert property (@(posedge clock) disable iff (reset)
      (push_fire && !pop_fire) |=> (count_ff == $past(count_ff) + QCNT_WIDTH'(1)))
      else $error("Queue fill count did not follow a push.");
`endif

endmodule

FILE: rtl/core/bwc_back.sv
// Divider back end: bit-serial quotients of the weighted sums and the result register.
module bwc_back import bwc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  bwc_blob_type           pop_blob,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [COORD_WIDTH-1:0] rsp_centroid_x,
   output logic [COORD_WIDTH-1:0] rsp_centroid_y,
   output logic [COUNT_WIDTH-1:0] rsp_blob_pixels
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [DIV_WIDTH-1:0]   rem_x_ff, rem_x_in;
   logic [DIV_WIDTH-1:0]   rem_y_ff, rem_y_in;
   logic [DIV_WIDTH-1:0]   div_ff, div_in;
   logic [COORD_WIDTH-1:0] qx_ff, qx_in;
   logic [COORD_WIDTH-1:0] qy_ff, qy_in;
   logic [STEP_WIDTH-1:0]  step_ff, step_in;
   logic                   satx_ff, satx_in;
   logic                   saty_ff, saty_in;
   logic                   zero_ff, zero_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   ge_x, ge_y;
   logic [DIV_WIDTH-1:0]   wsum_ext;

   assign wsum_ext  = DIV_WIDTH'(pop_blob.wsum);
   assign ge_x      = rem_x_ff >= div_ff;
   assign ge_y      = rem_y_ff >= div_ff;
   assign pop_ready = state_ff == ST_IDLE;
   assign rsp_valid = state_ff == ST_DONE;

   assign rsp_centroid_x  = zero_ff ? '0 : (satx_ff ? '1 : qx_ff);
   assign rsp_centroid_y  = zero_ff ? '0 : (saty_ff ? '1 : qy_ff);
   assign rsp_blob_pixels = count_ff;

   always_comb begin
      state_in = state_ff;
      rem_x_in = rem_x_ff;
      rem_y_in = rem_y_ff;
      div_in   = div_ff;
      qx_in    = qx_ff;
      qy_in    = qy_ff;
      step_in  = step_ff;
      satx_in  = satx_ff;
      saty_in  = saty_ff;
      zero_in  = zero_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               rem_x_in = DIV_WIDTH'(pop_blob.xsum);
               rem_y_in = DIV_WIDTH'(pop_blob.ysum);
               div_in   = wsum_ext << (COORD_WIDTH - 1);
               satx_in  = DIV_WIDTH'(pop_blob.xsum) >= (wsum_ext << COORD_WIDTH);
               saty_in  = DIV_WIDTH'(pop_blob.ysum) >= (wsum_ext << COORD_WIDTH);
               zero_in  = pop_blob.wsum == '0;
               count_in = pop_blob.count;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_x_in = ge_x ? rem_x_ff - div_ff : rem_x_ff;
            rem_y_in = ge_y ? rem_y_ff - div_ff : rem_y_ff;
            qx_in    = {qx_ff[COORD_WIDTH-2:0], ge_x};
            qy_in    = {qy_ff[COORD_WIDTH-2:0], ge_y};
            div_in   = div_ff >> 1;
            step_in  = step_ff + STEP_WIDTH'(1);
            if (step_ff == STEP_WIDTH'(COORD_WIDTH - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_x_ff <= rem_x_in;
      rem_y_ff <= rem_y_in;
      div_ff   <= div_in;
      qx_ff    <= qx_in;
      qy_ff    <= qy_in;
      step_ff  <= step_in;
      satx_ff  <= satx_in;
      saty_ff  <= saty_in;
      zero_ff  <= zero_in;
      count_ff <= count_in;
   end

`ifndef NO_ASSERTIONS
   a_result_after_divide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == ST_DIV))
      else $error("A result appeared without a completed division.");
`endif

endmodule

FILE: rtl/core/blob_weighted_centroid.sv
// Top level of the intensity-weighted blob centroid block.
// Pixels are taken one word per cycle, except while a blob that is kept waits for room in
// the queue, and accumulated into count, weight and weighted coordinate sums that saturate
// instead of wrapping. The word marked as the last pixel closes the blob; if its pixel count
// exceeds min_pixels (reset value 30, written through csr_we and csr_wdata; the user is to
// write it only while the block is idle, which the block itself does not enforce), the sums
// go through a two-entry queue to a bit-serial divider that loads the blob in the cycle it
// leaves the queue and then forms both quotients one coordinate bit at a time over all
// COORD_WIDTH = 12 bits; the next blob can leave the queue in the cycle after the result is
// accepted. The centroid is the truncated quotient of each coordinate sum by the weight sum,
// 0 for a zero weight sum and all ones when the quotient exceeds the coordinate range.
module blob_weighted_centroid import bwc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [MINPIX_WIDTH-1:0] csr_wdata,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [COORD_WIDTH-1:0]  req_pixel_x,
   input  logic [COORD_WIDTH-1:0]  req_pixel_y,
   input  logic [WEIGHT_WIDTH-1:0] req_pixel_weight,
   input  logic                    req_last_pixel,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [COORD_WIDTH-1:0]  rsp_centroid_x,
   output logic [COORD_WIDTH-1:0]  rsp_centroid_y,
   output logic [COUNT_WIDTH-1:0]  rsp_blob_pixels
);

   logic [MINPIX_WIDTH-1:0] min_pixels_ff, min_pixels_in;
   logic                    push_valid;
   logic                    push_ready;
   bwc_blob_type            push_blob;
   logic                    pop_valid;
   logic                    pop_ready;
   bwc_blob_type            pop_blob;

   assign min_pixels_in = csr_we ? csr_wdata : min_pixels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_pixels_ff <= MINPIX_WIDTH'(MINPIX_RESET);
      end else begin
         min_pixels_ff <= min_pixels_in;
      end
   end

   bwc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .min_pixels   (min_pixels_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .pixel_x      (req_pixel_x),
      .pixel_y      (req_pixel_y),
      .pixel_weight (req_pixel_weight),
      .last_pixel   (req_last_pixel),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_blob    (push_blob)
   );

   bwc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_blob  (push_blob),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_blob   (pop_blob)
   );

   bwc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_blob        (pop_blob),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_centroid_x  (rsp_centroid_x),
      .rsp_centroid_y  (rsp_centroid_y),
      .rsp_blob_pixels (rsp_blob_pixels)
   );

endmodule
